// ===== rtl/nsag_pkg.sv =====
// Shared types and constants for the nearest-neighbor scale address generator.
`default_nettype none

package nsag_pkg;

    // Default parameter values
    localparam int DEF_MAX_DIMENSION = 4096;
    localparam int DEF_ADDRESS_BITS  = 32;

    // Field widths
    localparam int ADDR_W     = 32;                 // base and output address width
    localparam int DIM_W      = 13;                 // size, pitch and counter width
    localparam int PROD_W     = 2 * DIM_W;          // 13 x 13 product
    localparam int COORD_W    = 12;                 // out_column / out_row
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 96;                 // 89 payload bits padded to bytes
    localparam int OUT_PAD_W  = OUT_DATA_W - (1 + 2 * ADDR_W + 2 * COORD_W);

    // Divider iterations: quotient is below the source size, so DIM_W bits
    localparam int DIV_STEPS  = DIM_W;
    localparam int STEP_W     = $clog2(DIV_STEPS + 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_BASE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_BASE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_PITCH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_HEIGHT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_PITCH    = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DSTART,
        ST_DIV,
        ST_ADDR,
        ST_PUT
    } t_state;

    typedef struct packed {
        logic accept;     // take the input beat, latch coordinates, advance counters
        logic mul_en;     // register the scale and row-offset products
        logic div_start;  // load both dividers
        logic addr_en;    // form source and destination addresses
        logic out_load;   // move the result into the output register
    } t_cmd;

    typedef struct packed {
        logic item_ok;    // beat on the input would produce a valid pixel
        logic div_last;   // dividers finish on this cycle
        logic out_free;   // output register can take a result
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/nsag_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module nsag_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [nsag_pkg::PROD_W-1:0]   i_dividend,
    input  wire logic [nsag_pkg::DIM_W-1:0]    i_divisor,
    output logic                               o_busy,
    output logic                               o_last,
    output logic [nsag_pkg::DIM_W-1:0]         o_quotient
);

    logic [nsag_pkg::DIM_W-1:0]  r_rem;
    logic [nsag_pkg::DIM_W-1:0]  r_quo;
    logic [nsag_pkg::DIM_W-1:0]  r_dvs;
    logic [nsag_pkg::STEP_W-1:0] r_cnt;
    logic                        r_busy;

    logic [nsag_pkg::DIM_W:0]    w_trial;
    logic                        w_ge;
    logic [nsag_pkg::DIM_W-1:0]  n_rem;

    // Remainder stays below the divisor, so the trial fits one extra bit
    always_comb begin
        w_trial = {r_rem, r_quo[nsag_pkg::DIM_W-1]};
        w_ge    = (w_trial >= {1'b0, r_dvs});
        if (w_ge) begin
            n_rem = nsag_pkg::DIM_W'(w_trial - {1'b0, r_dvs});
        end else begin
            n_rem = w_trial[nsag_pkg::DIM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= nsag_pkg::STEP_W'(nsag_pkg::DIV_STEPS);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - nsag_pkg::STEP_W'(1);
            r_busy <= (r_cnt != nsag_pkg::STEP_W'(1));
        end
    end

    // Quotient below 2^DIM_W means the upper dividend half is already below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[nsag_pkg::PROD_W-1:nsag_pkg::DIM_W];
            r_quo <= i_dividend[nsag_pkg::DIM_W-1:0];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[nsag_pkg::DIM_W-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_last     = r_busy && (r_cnt == nsag_pkg::STEP_W'(1));
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== rtl/nsag_ctrl.sv =====
// Sequencing state machine for the scale address generator.
`default_nettype none

module nsag_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire nsag_pkg::t_status i_status,
    output nsag_pkg::t_cmd         o_cmd
);

    nsag_pkg::t_state r_state;
    nsag_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nsag_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            nsag_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.item_ok ? nsag_pkg::ST_MUL : nsag_pkg::ST_PUT;
                end
            end
            nsag_pkg::ST_MUL:    n_state = nsag_pkg::ST_DSTART;
            nsag_pkg::ST_DSTART: n_state = nsag_pkg::ST_DIV;
            nsag_pkg::ST_DIV: begin
                if (i_status.div_last) begin
                    n_state = nsag_pkg::ST_ADDR;
                end
            end
            nsag_pkg::ST_ADDR:   n_state = nsag_pkg::ST_PUT;
            nsag_pkg::ST_PUT: begin
                if (i_status.out_free) begin
                    n_state = nsag_pkg::ST_IDLE;
                end
            end
            default:             n_state = nsag_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            nsag_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            nsag_pkg::ST_MUL:    o_cmd.mul_en    = 1'b1;
            nsag_pkg::ST_DSTART: o_cmd.div_start = 1'b1;
            nsag_pkg::ST_DIV:    o_cmd           = '0;
            nsag_pkg::ST_ADDR:   o_cmd.addr_en   = 1'b1;
            nsag_pkg::ST_PUT:    o_cmd.out_load  = i_status.out_free;
            default:             o_cmd           = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/nsag_dpath.sv =====
// Datapath: configuration, raster counters, scale products, dividers and output register.
`default_nettype none

module nsag_dpath #(
    parameter int MAX_DIMENSION = nsag_pkg::DEF_MAX_DIMENSION,
    parameter int ADDRESS_BITS  = nsag_pkg::DEF_ADDRESS_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [nsag_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [nsag_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                i_restart,
    input  wire nsag_pkg::t_cmd                      i_cmd,
    output nsag_pkg::t_status                        o_status,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output logic [nsag_pkg::OUT_DATA_W-1:0]          o_out_data,
    output logic                                     o_out_last
);

    localparam logic [31:0] MaxDim   = 32'(MAX_DIMENSION);
    localparam logic [nsag_pkg::ADDR_W-1:0] AddrMask = (ADDRESS_BITS >= nsag_pkg::ADDR_W) ?
        '1 : nsag_pkg::ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);

    // Configuration
    logic [nsag_pkg::ADDR_W-1:0] r_sbase, r_dbase;
    logic [nsag_pkg::DIM_W-1:0]  r_sw, r_sh, r_sp, r_dw, r_dh, r_dp;

    // Raster state
    logic [nsag_pkg::DIM_W-1:0]  r_col, r_row;
    logic                        r_active;

    // Item in flight
    logic [nsag_pkg::DIM_W-1:0]  r_x, r_y;
    logic                        r_ok, r_last;
    logic [nsag_pkg::PROD_W-1:0] r_prod_x, r_prod_y, r_dst_off;
    logic [nsag_pkg::ADDR_W-1:0] r_src, r_dst;

    // Output register
    logic                        r_out_valid;
    logic                        r_o_ok, r_o_last;
    logic [nsag_pkg::ADDR_W-1:0] r_o_src, r_o_dst;
    logic [nsag_pkg::COORD_W-1:0] r_o_col, r_o_row;

    logic [nsag_pkg::DIM_W-1:0]  w_x, w_y, w_qx, w_qy;
    logic                        w_act, w_cfg_ok, w_in_range, w_ok, w_x_end, w_y_end, w_last;
    logic                        w_busy_x, w_busy_y, w_last_x, w_last_y;

    function automatic logic dim_ok(input logic [nsag_pkg::DIM_W-1:0] d);
        return (d != '0) && (32'(d) <= MaxDim);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sbase <= '0;
            r_dbase <= '0;
            r_sw    <= '0;
            r_sh    <= '0;
            r_sp    <= '0;
            r_dw    <= '0;
            r_dh    <= '0;
            r_dp    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                nsag_pkg::CFG_SOURCE_BASE:   r_sbase <= i_cfg_data;
                nsag_pkg::CFG_DEST_BASE:     r_dbase <= i_cfg_data;
                nsag_pkg::CFG_SOURCE_WIDTH:  r_sw    <= i_cfg_data[nsag_pkg::DIM_W-1:0];
                nsag_pkg::CFG_SOURCE_HEIGHT: r_sh    <= i_cfg_data[nsag_pkg::DIM_W-1:0];
                nsag_pkg::CFG_SOURCE_PITCH:  r_sp    <= i_cfg_data[nsag_pkg::DIM_W-1:0];
                nsag_pkg::CFG_DEST_WIDTH:    r_dw    <= i_cfg_data[nsag_pkg::DIM_W-1:0];
                nsag_pkg::CFG_DEST_HEIGHT:   r_dh    <= i_cfg_data[nsag_pkg::DIM_W-1:0];
                nsag_pkg::CFG_DEST_PITCH:    r_dp    <= i_cfg_data[nsag_pkg::DIM_W-1:0];
                default:                     r_dp    <= r_dp;
            endcase
        end
    end

    // Classify the pixel the incoming beat would produce
    always_comb begin
        w_x        = i_restart ? '0 : r_col;
        w_y        = i_restart ? '0 : r_row;
        w_act      = i_restart || r_active;
        w_cfg_ok   = (r_sbase != '0) && (r_dbase != '0) && dim_ok(r_sw) && dim_ok(r_sh) &&
                     dim_ok(r_dw) && dim_ok(r_dh);
        w_in_range = (w_x < r_dw) && (w_y < r_dh);
        w_ok       = w_act && w_cfg_ok && w_in_range;
        w_x_end    = (nsag_pkg::DIM_W'(w_x + nsag_pkg::DIM_W'(1)) == r_dw);
        w_y_end    = (nsag_pkg::DIM_W'(w_y + nsag_pkg::DIM_W'(1)) == r_dh);
        w_last     = w_x_end && w_y_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_active <= 1'b0;
        end else if (i_cmd.accept) begin
            r_active <= w_ok && !w_last;
            if (w_ok && !w_last) begin
                if (w_x_end) begin
                    r_col <= '0;
                    r_row <= nsag_pkg::DIM_W'(w_y + nsag_pkg::DIM_W'(1));
                end else begin
                    r_col <= nsag_pkg::DIM_W'(w_x + nsag_pkg::DIM_W'(1));
                    r_row <= w_y;
                end
            end else begin
                r_col <= w_x;
                r_row <= w_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x    <= w_x;
            r_y    <= w_y;
            r_ok   <= w_ok;
            r_last <= w_last;
        end
        if (i_cmd.mul_en) begin
            r_prod_x  <= nsag_pkg::PROD_W'(r_x) * nsag_pkg::PROD_W'(r_sw);
            r_prod_y  <= nsag_pkg::PROD_W'(r_y) * nsag_pkg::PROD_W'(r_sh);
            r_dst_off <= nsag_pkg::PROD_W'(r_y) * nsag_pkg::PROD_W'(r_dp);
        end
        if (i_cmd.addr_en) begin
            r_src <= (r_sbase +
                      nsag_pkg::ADDR_W'(nsag_pkg::PROD_W'(w_qy) * nsag_pkg::PROD_W'(r_sp)) +
                      nsag_pkg::ADDR_W'(w_qx)) & AddrMask;
            r_dst <= (r_dbase + nsag_pkg::ADDR_W'(r_dst_off) + nsag_pkg::ADDR_W'(r_x)) &
                     AddrMask;
        end
    end

    nsag_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod_x),
        .i_divisor  (r_dw),
        .o_busy     (w_busy_x),
        .o_last     (w_last_x),
        .o_quotient (w_qx)
    );

    nsag_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod_y),
        .i_divisor  (r_dh),
        .o_busy     (w_busy_y),
        .o_last     (w_last_y),
        .o_quotient (w_qy)
    );

    // Output register: invalid results carry all-zero fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_ok   <= r_ok;
            r_o_last <= r_ok && r_last;
            r_o_src  <= r_ok ? r_src : '0;
            r_o_dst  <= r_ok ? r_dst : '0;
            r_o_col  <= r_ok ? r_x[nsag_pkg::COORD_W-1:0] : '0;
            r_o_row  <= r_ok ? r_y[nsag_pkg::COORD_W-1:0] : '0;
        end
    end

    assign o_status.item_ok  = w_ok;
    assign o_status.div_last = w_last_x && w_last_y && w_busy_x && w_busy_y;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_last  = r_o_last;
    assign o_out_data  = {{nsag_pkg::OUT_PAD_W{1'b0}}, r_o_row, r_o_col, r_o_dst, r_o_src, r_o_ok};

endmodule

`default_nettype wire

// ===== rtl/nearest_scale_address_generator_core.sv =====
// Top level of the nearest-neighbor scale address generator.
`default_nettype none

// Each input beat either restarts a frame (restart = 1) or steps it by one
// destination pixel in raster order, and produces exactly one output beat.
// A valid beat carries the destination word address, the source word address
// to copy from (source column floor(x*src_w/dst_w), row floor(y*src_h/dst_h)),
// the destination column and row, and tlast on the final pixel of the frame.
// A zero base, a zero or oversized dimension, a finished frame or counters
// outside a shrunken destination give a beat with every field zero.
// A valid pixel passes through multiply, divider start, the two 13-step
// restoring dividers that run side by side for the column and row scaling,
// address forming and hand-off; an invalid result goes straight to hand-off.
// Results wait in an output register; a held m_axis_tready stalls the hand-off
// and with it the next input beat. Write configuration only while idle.
module nearest_scale_address_generator_core #(
    parameter int MAX_DIMENSION = nsag_pkg::DEF_MAX_DIMENSION,
    parameter int ADDRESS_BITS  = nsag_pkg::DEF_ADDRESS_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [nsag_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [nsag_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Input stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [nsag_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [0] restart
    // Output stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [0] valid_res, [32:1] src_address, [64:33] dst_address,
    // [76:65] out_column, [88:77] out_row, upper bits zero
    output logic [nsag_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    output logic                                   m_axis_tlast   // frame_last
);

    nsag_pkg::t_cmd    w_cmd;
    nsag_pkg::t_status w_status;

    // Sequence one beat at a time through multiply, divide and address steps
    nsag_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Hold config, counters and the output register
    nsag_dpath #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .ADDRESS_BITS  (ADDRESS_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_restart   (s_axis_tdata[0]),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

    // One beat in flight: never ready right after taking a beat
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while a beat is still in flight");

    // Frame end only on a valid pixel
    a_last_is_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tdata[0])
        else $error("frame_last on an invalid result");

    // Invalid results carry all-zero fields
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[88:1] == '0))
        else $error("invalid result with nonzero fields");

    // Output valid rises only from a load by the controller
    a_load_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_cmd.out_load))
        else $error("output valid without a load");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the nearest-neighbor scale address generator core.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM      = nsag_pkg::DEF_MAX_DIMENSION;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int SETTLE       = 24;      // covers the time one pixel occupies the core
    localparam int RANDOM_BEATS = 820;
    localparam int WIDE_BEATS   = 64;

    // Frame geometry as held by the configuration registers
    typedef struct packed {
        logic [31:0] src_base;
        logic [31:0] dst_base;
        logic [12:0] src_w;
        logic [12:0] src_h;
        logic [12:0] src_pitch;
        logic [12:0] dst_w;
        logic [12:0] dst_h;
        logic [12:0] dst_pitch;
    } t_geom;

    // One copy-address result
    typedef struct packed {
        logic        valid;
        logic [31:0] src;
        logic [31:0] dst;
        logic [11:0] col;
        logic [11:0] row;
        logic        last;
    } t_pixel;

    typedef enum int {
        PACE_FIRST_MIX,     // sender idles 34 %, receiver 48 %
        PACE_SWAPPED_MIX,   // sender idles 48 %, receiver 34 %
        PACE_NONE           // both sides at full rate
    } t_pace;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [nsag_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [nsag_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [nsag_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;    // [0] restart
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // [0] valid_res, [32:1] src_address, [64:33] dst_address,
    // [76:65] out_column, [88:77] out_row, upper bits zero
    logic [nsag_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tlast;         // frame_last

    nearest_scale_address_generator_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Scaler state mirrored by the testbench
    t_geom       geo = '0;
    int unsigned next_col = 0;
    int unsigned next_row = 0;
    bit          frame_open = 1'b0;

    t_pixel      expected_pixels[$];
    int unsigned mismatches = 0;
    int unsigned beats_sent = 0;        // accepted input beats
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned cycle_count = 0;

    function automatic bit dim_ok(input logic [12:0] d);
        return d != 0 && d <= MAX_DIM;
    endfunction

    // Advance the mirrored scaler by one beat and return the pixel it yields.
    function automatic t_pixel scale_pixel(input bit restart);
        t_pixel          p;
        longint unsigned x, y, sx, sy, src, dst;
        p = '0;
        if (restart) begin
            next_col = 0;
            next_row = 0;
            frame_open = 1'b1;
        end
        // No frame in progress: nothing changes
        if (!frame_open)
            return p;
        // A zero base or a zero or oversized dimension ends the frame
        if (geo.src_base == 0 || geo.dst_base == 0 || !dim_ok(geo.src_w) ||
                !dim_ok(geo.src_h) || !dim_ok(geo.dst_w) || !dim_ok(geo.dst_h)) begin
            frame_open = 1'b0;
            return p;
        end
        x = next_col;
        y = next_row;
        // Destination shrank under the counters: end the frame
        if (x >= geo.dst_w || y >= geo.dst_h) begin
            frame_open = 1'b0;
            return p;
        end
        sx = (x * geo.src_w) / geo.dst_w;
        sy = (y * geo.src_h) / geo.dst_h;
        src = geo.src_base + sy * geo.src_pitch + sx;
        dst = geo.dst_base + y * geo.dst_pitch + x;
        p.valid = 1'b1;
        p.src   = 32'(src);
        p.dst   = 32'(dst);
        p.col   = 12'(x);
        p.row   = 12'(y);
        p.last  = (x + 1 == geo.dst_w) && (y + 1 == geo.dst_h);
        if (p.last) begin
            frame_open = 1'b0;
        end else if (x + 1 == geo.dst_w) begin
            next_col = 0;
            next_row = next_row + 1;
        end else begin
            next_col = next_col + 1;
        end
        return p;
    endfunction

    task automatic set_pace(input t_pace pace);
        case (pace)
            PACE_FIRST_MIX: begin
                send_idle_pct = 34;
                recv_idle_pct = 48;
            end
            PACE_SWAPPED_MIX: begin
                send_idle_pct = 48;
                recv_idle_pct = 34;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // Offer one beat, hold it until accepted, then log the pixel it must yield.
    // Leave tvalid high on return so back-to-back beats need no second update.
    task automatic send_beat(input bit restart);
        t_pixel want;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(nsag_pkg::IN_DATA_W-1){1'b0}}, restart};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        want = scale_pixel(restart);
        expected_pixels.push_back(want);
        beats_sent++;
    endtask

    // Drop the input, wait for every result, then let the core go quiet.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write all eight registers; junk above bit 12 of the narrow ones is dropped.
    task automatic load_config(input t_geom g);
        logic [31:0] regs[8];
        regs[int'(nsag_pkg::CFG_SOURCE_BASE)]   = g.src_base;
        regs[int'(nsag_pkg::CFG_DEST_BASE)]     = g.dst_base;
        regs[int'(nsag_pkg::CFG_SOURCE_WIDTH)]  = {19'($urandom), g.src_w};
        regs[int'(nsag_pkg::CFG_SOURCE_HEIGHT)] = {19'($urandom), g.src_h};
        regs[int'(nsag_pkg::CFG_SOURCE_PITCH)]  = {19'($urandom), g.src_pitch};
        regs[int'(nsag_pkg::CFG_DEST_WIDTH)]    = {19'($urandom), g.dst_w};
        regs[int'(nsag_pkg::CFG_DEST_HEIGHT)]   = {19'($urandom), g.dst_h};
        regs[int'(nsag_pkg::CFG_DEST_PITCH)]    = {19'($urandom), g.dst_pitch};
        for (int i = 0; i < 8; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= nsag_pkg::CFG_IDX_W'(i);
            i_cfg_data  <= regs[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        geo = g;
    endtask

    function automatic logic [12:0] pick_src_dim;
        int unsigned r;
        r = $urandom_range(99);
        if (r == 0)
            return '0;
        if (r == 1)
            return 13'($urandom_range(8191, MAX_DIM + 1));
        if (r < 7)
            return 13'd1;
        if (r < 12)
            return 13'(MAX_DIM);
        return 13'($urandom_range(MAX_DIM, 1));
    endfunction

    // Keep destination frames short except for an occasional wide dimension.
    function automatic logic [12:0] pick_dst_dim(input bit wide);
        int unsigned r;
        r = $urandom_range(99);
        if (r == 0)
            return '0;
        if (r == 1)
            return 13'($urandom_range(8191, MAX_DIM + 1));
        if (wide)
            return (r < 20) ? 13'(MAX_DIM) : 13'($urandom_range(MAX_DIM, 1));
        return 13'($urandom_range(8, 1));
    endfunction

    function automatic logic [31:0] pick_base;
        int unsigned r;
        r = $urandom_range(99);
        if (r < 2)
            return '0;
        if (r < 8)
            return 32'hFFFF_F000 | 32'($urandom_range(4095));
        return 32'($urandom);
    endfunction

    function automatic logic [12:0] pick_pitch;
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0)
            return '0;
        if (r == 1)
            return 13'h1FFF;
        return 13'($urandom_range(8191));
    endfunction

    function automatic t_geom random_geom;
        t_geom       g;
        int unsigned shape;
        shape = $urandom_range(19);
        g.src_base  = pick_base();
        g.dst_base  = pick_base();
        g.src_w     = pick_src_dim();
        g.src_h     = pick_src_dim();
        g.src_pitch = pick_pitch();
        g.dst_pitch = pick_pitch();
        g.dst_w     = pick_dst_dim(shape < 2);
        g.dst_h     = pick_dst_dim(shape == 2);
        return g;
    endfunction

    // Compare one field; X or Z on the port counts as a mismatch.
    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatches++;
        end
    endfunction

    // Check each accepted result beat against the oldest pending pixel.
    always @(posedge i_clk) begin : check_beat
        t_pixel want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: result beat with nothing pending, expected none, actual %h",
                         $time, m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("valid_res",   32'(want.valid), 32'(m_axis_tdata[0]));
                check_field("src_address", want.src,        m_axis_tdata[32:1]);
                check_field("dst_address", want.dst,        m_axis_tdata[64:33]);
                check_field("out_column",  32'(want.col),   32'(m_axis_tdata[76:65]));
                check_field("out_row",     32'(want.row),   32'(m_axis_tdata[88:77]));
                check_field("frame_last",  32'(want.last),  32'(m_axis_tlast));
                check_field("tdata pad",   '0,
                            32'(m_axis_tdata[nsag_pkg::OUT_DATA_W-1:89]));
            end
        end
    end

    // Random backpressure on the result side
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Registers still at reset: every beat is invalid, restart included.
    task automatic test_unconfigured;
        send_beat(1'b0);
        send_beat(1'b1);
        send_beat(1'b0);
    endtask

    // Full 3x2 frame, advances past its end, and a restart in mid-frame.
    task automatic test_small_frame;
        drain();
        load_config('{src_base: 32'h0000_1000, dst_base: 32'h0002_0000,
                      src_w: 13'd5, src_h: 13'd3, src_pitch: 13'd7,
                      dst_w: 13'd3, dst_h: 13'd2, dst_pitch: 13'd4});
        send_beat(1'b1);
        repeat (5) send_beat(1'b0);
        repeat (2) send_beat(1'b0);
        send_beat(1'b1);
        send_beat(1'b0);
        send_beat(1'b1);
        send_beat(1'b0);
    endtask

    // Each kind of bad configuration, one restart apiece.
    task automatic test_bad_config;
        t_geom g;
        for (int v = 0; v < 8; v++) begin
            g = '{src_base: 32'h0000_0040, dst_base: 32'h0000_8000,
                  src_w: 13'd16, src_h: 13'd16, src_pitch: 13'd16,
                  dst_w: 13'd4, dst_h: 13'd4, dst_pitch: 13'd4};
            case (v)
                0: g.src_base = '0;
                1: g.dst_base = '0;
                2: g.src_w    = '0;
                3: g.src_h    = '0;
                4: g.dst_w    = '0;
                5: g.dst_h    = '0;
                6: g.src_w    = 13'(MAX_DIM + 1);
                default: g.dst_h = 13'h1FFF;
            endcase
            drain();
            load_config(g);
            send_beat(1'b1);
        end
        send_beat(1'b0);
    endtask

    // Shrink the destination under a running frame: the next beat ends it.
    task automatic test_shrink_mid_frame;
        t_geom g;
        g = '{src_base: 32'h0010_0000, dst_base: 32'h0020_0000,
              src_w: 13'd7, src_h: 13'd5, src_pitch: 13'd9,
              dst_w: 13'd4, dst_h: 13'd3, dst_pitch: 13'd6};
        drain();
        load_config(g);
        send_beat(1'b1);
        repeat (5) send_beat(1'b0);
        drain();
        g.dst_w = 13'd2;
        load_config(g);
        repeat (2) send_beat(1'b0);
    endtask

    // Addresses that wrap past 2^32, then a frame of a single pixel.
    task automatic test_wrap_and_single;
        t_geom g;
        g = '{src_base: 32'hFFFF_FFF0, dst_base: 32'hFFFF_FFFF,
              src_w: 13'(MAX_DIM), src_h: 13'(MAX_DIM), src_pitch: 13'h1FFF,
              dst_w: 13'd2, dst_h: 13'd2, dst_pitch: 13'h1FFF};
        drain();
        load_config(g);
        send_beat(1'b1);
        repeat (3) send_beat(1'b0);
        drain();
        g.dst_w = 13'd1;
        g.dst_h = 13'd1;
        load_config(g);
        send_beat(1'b1);
        send_beat(1'b0);
    endtask

    // Mostly complete frames with random geometry; a few stray restarts.
    task automatic test_random_frames;
        int unsigned start, done, pixels, steps;
        start = beats_sent;
        done  = 0;
        while (done < RANDOM_BEATS) begin
            set_pace(t_pace'((done * 3) / RANDOM_BEATS));
            if (done == 0 || $urandom_range(9) < 4) begin
                drain();
                load_config(random_geom());
            end
            pixels = int'(geo.dst_w) * int'(geo.dst_h);
            if (pixels == 0 || pixels > 80)
                steps = $urandom_range(40);
            else
                steps = pixels - 1 + $urandom_range(2);
            send_beat(1'b1);
            repeat (steps) send_beat($urandom_range(99) < 3);
            done = beats_sent - start;
        end
    endtask

    // Full-size destination dimensions: a long first row, then a tall single column.
    task automatic test_wide_span;
        set_pace(PACE_NONE);
        drain();
        load_config('{src_base: 32'h0000_0001, dst_base: 32'h8000_0000,
                      src_w: 13'd1, src_h: 13'(MAX_DIM), src_pitch: 13'h1FFF,
                      dst_w: 13'(MAX_DIM), dst_h: 13'd1, dst_pitch: 13'h1FFF});
        send_beat(1'b1);
        repeat (WIDE_BEATS - 1) send_beat(1'b0);
        drain();
        load_config('{src_base: 32'h0000_0100, dst_base: 32'h0000_0001,
                      src_w: 13'(MAX_DIM), src_h: 13'd3, src_pitch: 13'd4095,
                      dst_w: 13'd1, dst_h: 13'(MAX_DIM), dst_pitch: 13'h1FFF});
        send_beat(1'b1);
        repeat (WIDE_BEATS - 1) send_beat(1'b0);
    endtask

    initial begin
        set_pace(PACE_FIRST_MIX);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_unconfigured();
        test_small_frame();
        test_bad_config();
        test_shrink_mid_frame();
        test_wrap_and_single();
        test_random_frames();
        test_wide_span();

        drain();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
